[rtl/dbu_pkg.sv]
// ----------------------------------------------------------------------------
// Date decrement by unit: shared package
// Opcodes, widths and the month length table used by the sequencer and
// the top level.
// ----------------------------------------------------------------------------
package dbu_pkg;

	// Default width of the internal year register.
	localparam int unsigned DBU_YEAR_BITS = 16;

	// Width of the step counter: a millennium request needs count * 10 steps.
	localparam int unsigned DBU_CNT_BITS = 20;

	// Field widths of one transaction.
	localparam int unsigned DBU_OP_BITS    = 4;
	localparam int unsigned DBU_COUNT_BITS = 16;
	localparam int unsigned DBU_YEAR_IO    = 16;
	localparam int unsigned DBU_MONTH_BITS = 4;
	localparam int unsigned DBU_DAY_BITS   = 5;

	// Packed stream widths, rounded up to whole bytes.
	localparam int unsigned DBU_S_DATA_BITS = 48;
	localparam int unsigned DBU_M_DATA_BITS = 32;

	// Unit codes.
	typedef enum logic [DBU_OP_BITS-1:0] {
		OP_DAY         = 4'd0,
		OP_WEEK        = 4'd1,
		OP_MONTH       = 4'd2,
		OP_YEAR        = 4'd3,
		OP_YEAR_JUMP   = 4'd4,
		OP_DECADE      = 4'd5,
		OP_DECADE_JUMP = 4'd6,
		OP_CENTURY     = 4'd7,
		OP_MILLENNIUM  = 4'd8
	} op_t;

	// Month numbers that the step logic tests for.
	localparam logic [DBU_MONTH_BITS-1:0] MON_JAN = 4'd1;
	localparam logic [DBU_MONTH_BITS-1:0] MON_FEB = 4'd2;
	localparam logic [DBU_MONTH_BITS-1:0] MON_MAR = 4'd3;
	localparam logic [DBU_MONTH_BITS-1:0] MON_DEC = 4'd12;

	localparam logic [DBU_DAY_BITS-1:0] DAY_LEAP_FEB = 5'd29;
	localparam logic [DBU_DAY_BITS-1:0] DAY_FEB      = 5'd28;
	localparam logic [DBU_DAY_BITS-1:0] DAY_DEC      = 5'd31;

	// Request to the leap year unit.
	typedef struct packed {
		logic start;
	} leap_req_t;

	// Answer from the leap year unit.
	typedef struct packed {
		logic done;
		logic leap;
	} leap_rsp_t;

	// Length of a month; February depends on the leap flag.
	function automatic logic [DBU_DAY_BITS-1:0] month_len(
		input logic [DBU_MONTH_BITS-1:0] mon,
		input logic                      lp
	);
		logic [DBU_DAY_BITS-1:0] len;
		case (mon)
			4'd2:    len = lp ? 5'd29 : 5'd28;
			4'd4:    len = 5'd30;
			4'd6:    len = 5'd30;
			4'd9:    len = 5'd30;
			4'd11:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

[rtl/dbu_leap.sv]
// ----------------------------------------------------------------------------
// Date decrement by unit: leap year unit
// Folds the year magnitude down modulo 25, one fold per cycle, then decides
// from the low bits and the folded value whether the year is a leap year.
// ----------------------------------------------------------------------------
module dbu_leap
	import dbu_pkg::*;
#(
	parameter int unsigned YEAR_BITS = DBU_YEAR_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  leap_req_t            req,
	input  logic [YEAR_BITS-1:0] year,
	output leap_rsp_t            rsp
);

	logic                 busy_q;
	logic [YEAR_BITS-1:0] val_q;
	logic [3:0]           low_q;
	logic [YEAR_BITS-1:0] mag;
	logic [YEAR_BITS-1:0] hi;
	logic [YEAR_BITS-1:0] fold;
	logic                 fits8;
	logic [7:0]           prod;
	logic                 div25;

	// Magnitude of the signed year; the most negative year maps to itself.
	assign mag = year[YEAR_BITS-1] ? (~year + YEAR_BITS'(1)) : year;

	// 256 is 6 modulo 25, so the bits above the low byte fold down times six.
	// Each fold keeps the value modulo 25 and shrinks it until it fits a byte.
	assign hi    = YEAR_BITS'(val_q[YEAR_BITS-1:8]);
	assign fold  = (hi << 2) + (hi << 1) + YEAR_BITS'(val_q[7:0]);
	assign fits8 = (val_q[YEAR_BITS-1:8] == '0);

	// 41 is the inverse of 25 modulo 256: a byte is a multiple of 25 exactly
	// when its product with 41, cut to a byte, is at most 10.
	assign prod  = val_q[7:0] * 8'd41;
	assign div25 = (prod <= 8'd10);

	// Control of the fold loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && fits8) begin
			busy_q <= 1'b0;
		end
	end

	// Folded value and the low magnitude bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			val_q <= mag;
			low_q <= mag[3:0];
		end else if (busy_q && !fits8) begin
			val_q <= fold;
		end
	end

	// Leap: divisible by 4 and not by 100, or by 400. With the magnitude a
	// multiple of 4, a multiple of 100 is a multiple of 25, and a multiple
	// of 400 is in addition a multiple of 16.
	assign rsp.done = busy_q && fits8;
	assign rsp.leap = (low_q[1:0] == 2'b00) && (!div25 || (low_q == 4'b0000));

endmodule

[rtl/dbu_core.sv]
// ----------------------------------------------------------------------------
// Date decrement by unit: step sequencer
// Holds the working date and a step counter and moves the date back one
// day, one month or one year increment per step, asking the leap year
// unit whenever a February length or a 29 February clamp depends on it.
// ----------------------------------------------------------------------------
module dbu_core
	import dbu_pkg::*;
#(
	parameter int unsigned YEAR_BITS = DBU_YEAR_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Request side
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [DBU_OP_BITS-1:0]    opcode,
	input  logic [DBU_COUNT_BITS-1:0] count,
	input  logic [DBU_YEAR_IO-1:0]    year_in,
	input  logic [DBU_MONTH_BITS-1:0] month_in,
	input  logic [DBU_DAY_BITS-1:0]   day_in,
	// Result side
	output logic                      res_valid,
	input  logic                      res_ack,
	output logic [DBU_YEAR_IO-1:0]    year_out,
	output logic [DBU_MONTH_BITS-1:0] month_out,
	output logic [DBU_DAY_BITS-1:0]   day_out
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_LEAP,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MODE_DAY,
		MODE_MONTH,
		MODE_YEAR
	} mode_t;

	state_t                    state_q;
	mode_t                     mode_q;
	logic [YEAR_BITS-1:0]      year_q;
	logic [DBU_MONTH_BITS-1:0] mon_q;
	logic [DBU_DAY_BITS-1:0]   day_q;
	logic [DBU_CNT_BITS-1:0]   cnt_q;
	logic [YEAR_BITS-1:0]      delta_q;
	logic                      pend_q;
	logic                      leap_q;
	logic                      lvalid_q;

	logic [DBU_MONTH_BITS-1:0] mon_san;
	logic [DBU_DAY_BITS-1:0]   day_san;
	logic [31:0]               year_ext;
	logic [DBU_CNT_BITS-1:0]   cnt_one;
	logic [DBU_CNT_BITS-1:0]   cnt_x7;
	logic [DBU_CNT_BITS-1:0]   cnt_x10;
	logic [31:0]               jump10;
	logic [31:0]               jump1;
	logic [DBU_MONTH_BITS-1:0] mon_prev;
	logic [DBU_DAY_BITS-1:0]   len_prev;
	logic                      need_leap;
	logic [31:0]               year_wide;
	leap_req_t                 leap_req;
	leap_rsp_t                 leap_rsp;

	// Input cleanup and step counts.
	always_comb begin
		mon_san = month_in;
		if (month_in < MON_JAN) mon_san = MON_JAN;
		if (month_in > MON_DEC) mon_san = MON_DEC;
		day_san  = (day_in == '0) ? DBU_DAY_BITS'(1) : day_in;
		year_ext = 32'(signed'(year_in));
		cnt_one  = DBU_CNT_BITS'(count);
		cnt_x7   = (cnt_one << 3) - cnt_one;
		cnt_x10  = (cnt_one << 3) + (cnt_one << 1);
		jump1    = 32'(count);
		jump10   = 32'(cnt_x10);
	end

	// Previous month and its length under the current leap flag.
	assign mon_prev = mon_q - DBU_MONTH_BITS'(1);
	assign len_prev = month_len(mon_prev, leap_q);

	// A step needs the leap flag of the current year.
	always_comb begin
		case (mode_q)
			MODE_DAY:   need_leap = (day_q <= DBU_DAY_BITS'(1)) && (mon_q == MON_MAR);
			MODE_MONTH: need_leap = (mon_q == MON_MAR);
			MODE_YEAR:  need_leap = pend_q && (mon_q == MON_FEB) && (day_q == DAY_LEAP_FEB);
			default:    need_leap = 1'b0;
		endcase
	end

	assign leap_req.start = (state_q == ST_RUN) && need_leap && !lvalid_q;

	dbu_leap #(
		.YEAR_BITS (YEAR_BITS)
	) u_leap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (leap_req),
		.year   (year_q),
		.rsp    (leap_rsp)
	);

	// Sequencer and working date.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_DAY;
			pend_q   <= 1'b0;
			lvalid_q <= 1'b0;
			leap_q   <= 1'b0;
			cnt_q    <= '0;
			year_q   <= '0;
			mon_q    <= MON_JAN;
			day_q    <= DBU_DAY_BITS'(1);
			delta_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q  <= ST_RUN;
						year_q   <= year_ext[YEAR_BITS-1:0];
						mon_q    <= mon_san;
						day_q    <= day_san;
						pend_q   <= 1'b0;
						lvalid_q <= 1'b0;
						case (opcode)
							OP_DAY: begin
								mode_q  <= MODE_DAY;
								cnt_q   <= cnt_one;
								delta_q <= YEAR_BITS'(1);
							end
							OP_WEEK: begin
								mode_q  <= MODE_DAY;
								cnt_q   <= cnt_x7;
								delta_q <= YEAR_BITS'(1);
							end
							OP_MONTH: begin
								mode_q  <= MODE_MONTH;
								cnt_q   <= cnt_one;
								delta_q <= YEAR_BITS'(1);
							end
							OP_YEAR: begin
								mode_q  <= MODE_YEAR;
								cnt_q   <= cnt_one;
								delta_q <= YEAR_BITS'(1);
							end
							OP_YEAR_JUMP: begin
								mode_q  <= MODE_YEAR;
								cnt_q   <= DBU_CNT_BITS'(1);
								delta_q <= jump1[YEAR_BITS-1:0];
							end
							OP_DECADE: begin
								mode_q  <= MODE_YEAR;
								cnt_q   <= cnt_one;
								delta_q <= YEAR_BITS'(10);
							end
							OP_DECADE_JUMP: begin
								mode_q  <= MODE_YEAR;
								cnt_q   <= DBU_CNT_BITS'(1);
								delta_q <= jump10[YEAR_BITS-1:0];
							end
							OP_CENTURY: begin
								mode_q  <= MODE_YEAR;
								cnt_q   <= cnt_one;
								delta_q <= YEAR_BITS'(100);
							end
							OP_MILLENNIUM: begin
								mode_q  <= MODE_YEAR;
								cnt_q   <= cnt_x10;
								delta_q <= YEAR_BITS'(100);
							end
							default: begin
								// Unknown unit: the cleaned date goes out as is.
								mode_q  <= MODE_DAY;
								cnt_q   <= '0;
								delta_q <= YEAR_BITS'(1);
							end
						endcase
					end
				end

				ST_RUN: begin
					if (need_leap && !lvalid_q) begin
						state_q <= ST_LEAP;
					end else begin
						case (mode_q)
							MODE_YEAR: begin
								if (pend_q) begin
									// Clamp 29 February once the new year is known.
									pend_q <= 1'b0;
									if (need_leap && !leap_q) begin
										day_q <= DAY_FEB;
									end
								end else if (cnt_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									year_q   <= year_q - delta_q;
									cnt_q    <= cnt_q - DBU_CNT_BITS'(1);
									pend_q   <= 1'b1;
									lvalid_q <= 1'b0;
								end
							end
							MODE_MONTH: begin
								if (cnt_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									cnt_q <= cnt_q - DBU_CNT_BITS'(1);
									if (mon_q == MON_JAN) begin
										// December is 31 days, so the day always fits.
										mon_q    <= MON_DEC;
										year_q   <= year_q - YEAR_BITS'(1);
										lvalid_q <= 1'b0;
									end else begin
										mon_q <= mon_prev;
										if (day_q > len_prev) begin
											day_q <= len_prev;
										end
									end
								end
							end
							default: begin
								// Day steps, borrowing across month and year ends.
								if (cnt_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									cnt_q <= cnt_q - DBU_CNT_BITS'(1);
									if (day_q <= DBU_DAY_BITS'(1)) begin
										if (mon_q == MON_JAN) begin
											mon_q    <= MON_DEC;
											day_q    <= DAY_DEC;
											year_q   <= year_q - YEAR_BITS'(1);
											lvalid_q <= 1'b0;
										end else begin
											mon_q <= mon_prev;
											day_q <= len_prev;
										end
									end else begin
										day_q <= day_q - DBU_DAY_BITS'(1);
									end
								end
							end
						endcase
					end
				end

				ST_LEAP: begin
					if (leap_rsp.done) begin
						leap_q   <= leap_rsp.leap;
						lvalid_q <= 1'b1;
						state_q  <= ST_RUN;
					end
				end

				ST_DONE: begin
					if (res_ack) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result view: the year is sign-extended, then cut to the output width.
	assign year_wide = 32'(signed'(year_q));
	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign year_out  = year_wide[DBU_YEAR_IO-1:0];
	assign month_out = mon_q;
	assign day_out   = day_q;

endmodule

[rtl/date_decrement_by_unit.sv]
// ----------------------------------------------------------------------------
// Date decrement by unit
// Moves a Gregorian date back by a count of days, weeks, months, years,
// decades, centuries or millennia.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. After acceptance the sequencer
// makes one step per cycle while no leap check holds it: count steps for
// days and months, 7 * count for weeks and count for the year type units,
// each followed by a 29 February check, with 10 * count century steps for
// millennia; jump units take a single step. Whenever a step needs to know
// whether the current year is a leap year and the answer is not cached,
// the modulo-25 folding unit holds the sequencer while it folds the year,
// a 16-bit value by default. Day and month units ask at most once per year
// visited; year type units once per step while the date is 29 February.
// The longest request is a millennium count of 65535: 655,350 century
// steps, with a leap check per step while 29 February stays on leap years.
// The result sits in an output register, so the next transaction is taken
// while the previous result waits for the downstream side.
// ----------------------------------------------------------------------------
module date_decrement_by_unit
	import dbu_pkg::*;
#(
	parameter int unsigned YEAR_BITS = DBU_YEAR_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input stream
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// opcode[3:0], count[19:4], year_in[35:20], month_in[39:36],
	// day_in[44:40], zero fill [47:45]
	input  logic [DBU_S_DATA_BITS-1:0] s_axis_tdata,
	// Output stream
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// year_out[15:0], month_out[19:16], day_out[24:20], zero fill [31:25]
	output logic [DBU_M_DATA_BITS-1:0] m_axis_tdata
);

	logic                      res_valid;
	logic                      res_ack;
	logic [DBU_YEAR_IO-1:0]    year_res;
	logic [DBU_MONTH_BITS-1:0] month_res;
	logic [DBU_DAY_BITS-1:0]   day_res;
	logic                      out_valid_q;
	logic [DBU_YEAR_IO-1:0]    year_out_q;
	logic [DBU_MONTH_BITS-1:0] month_out_q;
	logic [DBU_DAY_BITS-1:0]   day_out_q;

	dbu_core #(
		.YEAR_BITS (YEAR_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.opcode    (s_axis_tdata[3:0]),
		.count     (s_axis_tdata[19:4]),
		.year_in   (s_axis_tdata[35:20]),
		.month_in  (s_axis_tdata[39:36]),
		.day_in    (s_axis_tdata[44:40]),
		.res_valid (res_valid),
		.res_ack   (res_ack),
		.year_out  (year_res),
		.month_out (month_res),
		.day_out   (day_res)
	);

	// The result moves into the output register when it is empty or draining.
	assign res_ack = res_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (res_ack) begin
			year_out_q  <= year_res;
			month_out_q <= month_res;
			day_out_q   <= day_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, day_out_q, month_out_q, year_out_q};

endmodule
